>>> hdl/fiso_pkg.sv
// Package with the shared types, codes and constants of the flat index mapper.
package fiso_pkg;

  // Field widths of the item and result beats.
  localparam int SLOT_W   = 10;
  localparam int LEN_W    = 16;
  localparam int INDEX_W  = 26;
  localparam int COUNT_W  = 11;
  localparam int SEGNUM_W = 10;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;

  // Packed widths of the stream payloads.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  // Default table depth and reset value of the segment count.
  localparam int DEF_MAX_SEGMENTS = 1024;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Item opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNSORTED = 2'd1,
    ST_BEYOND   = 2'd2
  } status_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_WAIT
  } back_state_t;

  // Decoded command handed from front to back.
  typedef struct packed {
    logic                is_map;
    logic                slot_ok;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    len;
    logic [INDEX_W-1:0]  idx;
    logic                start;
  } cmd_t;

endpackage

>>> hdl/flat_index_to_segment_offset.sv
// Top level of the flat index to segment and offset mapper.
// A write passes the front holding register and the command queue and reaches the table when
// the back end takes it; a map takes the same path, then the back end steps the cursor over
// segments ending at or below its index, or flags it as backwards or past the last segment.
// The back end takes a new command only when idle. Reset: synchronous active-low; cursor and
// base clear, segment count becomes 1, and the length table is undefined until written.
module flat_index_to_segment_offset
  import fiso_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: segment count.
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data,
  // Input beats.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata: segment_slot [9:0], segment_len [25:10], flat_index [51:26],
  // batch_start [52], zero fill [55:53].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: opcode [0].
  input  logic                   in_tuser,
  // Result beats.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: segment_number [9:0], offset_in_segment [25:10], zero fill [31:26].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: status [1:0].
  output logic [STATUS_W-1:0]    out_tuser
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  fiso_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  fiso_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  fiso_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

>>> hdl/fiso_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fiso_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/fiso_front.sv
// Front end: accepts input beats, decodes them and holds one command.
module fiso_front
  import fiso_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take;

  // A new beat is taken when the holding register is empty or drains now.
  assign in_tready = !valid_r || cmd_ready;
  assign take      = in_tvalid && in_tready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  // Unpack and classify the beat.
  always_comb begin
    cmd_nxt = cmd_r;
    if (take) begin
      cmd_nxt.is_map  = (in_tuser == OP_MAP);
      cmd_nxt.slot    = in_tdata[SLOT_W-1:0];
      cmd_nxt.slot_ok = (32'(in_tdata[SLOT_W-1:0]) < MAX_SEGMENTS);
      cmd_nxt.len     = in_tdata[SLOT_W+LEN_W-1:SLOT_W];
      cmd_nxt.idx     = in_tdata[SLOT_W+LEN_W+INDEX_W-1:SLOT_W+LEN_W];
      cmd_nxt.start   = in_tdata[SLOT_W+LEN_W+INDEX_W];
    end
  end

  // Holding register occupancy.
  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

>>> hdl/fiso_queue.sv
// Short command queue between the front end and the back end.
module fiso_queue
  import fiso_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              push, pop;

  assign push_ready = (fill_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/fiso_back.sv
// Back end: applies table writes and walks the cursor for map commands.
module fiso_back
  import fiso_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]    out_tuser
);

  localparam int ADDR_W = $clog2(MAX_SEGMENTS);

  back_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic [COUNT_W-1:0]   count_eff;
  logic [COUNT_W-1:0]   cursor_r, cursor_nxt;
  logic [INDEX_W-1:0]   base_r, base_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic [INDEX_W-1:0]   base_eff;
  logic                 out_valid_r, out_valid_nxt;
  logic [SEGNUM_W-1:0]  out_seg_r, out_seg_nxt;
  logic [OFFSET_W-1:0]  out_off_r, out_off_nxt;
  status_t              out_st_r, out_st_nxt;
  logic                 out_free;
  logic                 pop;
  logic                 past_end;
  logic [INDEX_W:0]     end_sum;
  logic                 advance;
  logic [INDEX_W-1:0]   offset_full;
  logic                 ram_we;
  logic                 ram_re;
  logic [LEN_W-1:0]     ram_rd_data;

  // Segment count register, clamped to the table depth when used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  assign count_eff = (32'(count_r) > MAX_SEGMENTS) ? COUNT_W'(MAX_SEGMENTS) : count_r;

  // Length table.
  fiso_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ADDR_W'(cmd.slot)),
    .wr_data (cmd.len),
    .rd_en   (ram_re),
    .rd_addr (ADDR_W'(cursor_r)),
    .rd_data (ram_rd_data)
  );

  // A map is taken only when the result register will be free for it.
  assign out_free  = !out_valid_r || out_tready;
  assign cmd_ready = (state_r == S_IDLE) && (!cmd.is_map || out_free);
  assign pop       = cmd_valid && cmd_ready;
  assign ram_we    = pop && !cmd.is_map && cmd.slot_ok;
  assign base_eff  = cmd.start ? '0 : base_r;
  assign past_end  = (cursor_r >= count_eff);
  assign ram_re    = (state_r == S_TEST) && !past_end;
  assign end_sum     = {1'b0, base_r} + (INDEX_W+1)'(ram_rd_data);
  assign advance     = ({1'b0, idx_r} >= end_sum);
  assign offset_full = idx_r - base_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop && cmd.is_map && !(cmd.idx < base_eff)) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        state_nxt = past_end ? S_IDLE : S_WAIT;
      end
      S_WAIT: begin
        state_nxt = advance ? S_TEST : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and result register updates.
  always_comb begin
    cursor_nxt    = cursor_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_seg_nxt   = out_seg_r;
    out_off_nxt   = out_off_r;
    out_st_nxt    = out_st_r;
    case (state_r)
      S_IDLE: begin
        if (pop && cmd.is_map) begin
          idx_nxt  = cmd.idx;
          base_nxt = base_eff;
          if (cmd.start) begin
            cursor_nxt = '0;
          end
          if (cmd.idx < base_eff) begin
            out_valid_nxt = 1'b1;
            out_seg_nxt   = '0;
            out_off_nxt   = '0;
            out_st_nxt    = ST_UNSORTED;
          end
        end
      end
      S_TEST: begin
        if (past_end) begin
          out_valid_nxt = 1'b1;
          out_seg_nxt   = '0;
          out_off_nxt   = '0;
          out_st_nxt    = ST_BEYOND;
        end
      end
      S_WAIT: begin
        if (advance) begin
          base_nxt   = end_sum[INDEX_W-1:0];
          cursor_nxt = cursor_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_seg_nxt   = cursor_r[SEGNUM_W-1:0];
          out_off_nxt   = offset_full[OFFSET_W-1:0];
          out_st_nxt    = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    out_seg_r <= out_seg_nxt;
    out_off_r <= out_off_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SEGNUM_W-OFFSET_W){1'b0}}, out_off_r, out_seg_r};
  assign out_tuser  = out_st_r;

endmodule

>>> tb/sv/flat_index_to_segment_offset_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the flat index to segment and offset mapper.
module flat_index_to_segment_offset_test;
  import fiso_pkg::*;

  localparam int TBL_DEPTH = DEF_MAX_SEGMENTS;
  localparam int IDLE_LIMIT = 10000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 100;
  localparam int unsigned INDEX_MAX = (1 << INDEX_W) - 1;

  typedef struct {
    logic [SEGNUM_W-1:0] seg;
    logic [OFFSET_W-1:0] off;
    status_t             st;
  } seg_result_t;

  typedef enum {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_HOLD
  } sink_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [COUNT_W-1:0]     cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  // Mirror of the block state used to predict each result.
  logic [LEN_W-1:0] len_mirror [TBL_DEPTH];
  int unsigned      walk_seg;
  int unsigned      walk_base;
  int unsigned      seg_count_mirror;
  seg_result_t      expected_results [$];

  int err_count;
  int map_beats;
  int write_beats;
  int cfg_writes;
  int ok_results;
  int unsorted_results;
  int beyond_results;
  int burst_left;
  int idle_cycles;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  flat_index_to_segment_offset #(
    .MAX_SEGMENTS(TBL_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Walk the mirrored table for one map beat and queue the expected result.
  function automatic void predict_map(input logic [INDEX_W-1:0] idx, input logic start);
    seg_result_t r;
    int unsigned lim;
    if (start) begin
      walk_seg = 0;
      walk_base = 0;
    end
    lim = (seg_count_mirror > TBL_DEPTH) ? TBL_DEPTH : seg_count_mirror;
    r.seg = '0;
    r.off = '0;
    if (idx < walk_base) begin
      r.st = ST_UNSORTED;
    end else begin
      while (walk_seg < lim && idx >= walk_base + len_mirror[walk_seg]) begin
        walk_base += len_mirror[walk_seg];
        walk_seg++;
      end
      if (walk_seg >= lim) begin
        r.st = ST_BEYOND;
      end else begin
        r.st = ST_OK;
        r.seg = walk_seg[SEGNUM_W-1:0];
        r.off = OFFSET_W'(idx - walk_base);
      end
    end
    expected_results.push_back(r);
  endfunction

  // Total number of samples held in the first n table entries.
  function automatic int unsigned table_span(input int unsigned n);
    int unsigned total;
    int unsigned i;
    total = 0;
    for (i = 0; i < n && i < TBL_DEPTH; i++) total += len_mirror[i];
    return total;
  endfunction

  // Send one input beat, with bursts and random gaps between them.
  task automatic send_beat(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [LEN_W-1:0] len, input logic [INDEX_W-1:0] idx,
                           input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = IN_TDATA_W'({start, idx, len, slot});
    do @(posedge clk); while (in_tready !== 1'b1);
    if (op == OP_MAP) begin
      predict_map(idx, start);
      map_beats++;
    end else begin
      len_mirror[slot] = len;
      write_beats++;
    end
  endtask

  // Stop sending, wait for every expected result, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the segment count register while the block is idle.
  task automatic set_segment_count(input logic [COUNT_W-1:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    seg_count_mirror = value;
    cfg_writes++;
  endtask

  // Load every table entry so that no walk ever reads an unwritten one.
  task automatic test_table_fill();
    int i;
    for (i = 0; i < TBL_DEPTH; i++)
      send_beat(OP_WRITE, SLOT_W'(i), LEN_W'($urandom), INDEX_W'($urandom),
                1'($urandom_range(0, 1)));
  endtask

  // The segment count after reset is one.
  task automatic test_reset_count();
    send_beat(OP_WRITE, '0, LEN_W'(10), '0, 1'b0);
    send_beat(OP_MAP, '0, '0, INDEX_W'(0), 1'b1);
    send_beat(OP_MAP, '0, '0, INDEX_W'(9), 1'b0);
    send_beat(OP_MAP, '0, '0, INDEX_W'(10), 1'b0);
  endtask

  // Hand-built table with empty segments, a full-length segment and both error kinds.
  task automatic test_directed_walk();
    set_segment_count(COUNT_W'(5));
    send_beat(OP_WRITE, SLOT_W'(1023), LEN_W'(16'hFFFF), '0, 1'b0);
    send_beat(OP_WRITE, SLOT_W'(0), LEN_W'(0), '0, 1'b0);
    send_beat(OP_WRITE, SLOT_W'(1), LEN_W'(5), '0, 1'b0);
    send_beat(OP_WRITE, SLOT_W'(2), LEN_W'(16'hFFFF), '0, 1'b0);
    send_beat(OP_WRITE, SLOT_W'(3), LEN_W'(0), '0, 1'b0);
    send_beat(OP_WRITE, SLOT_W'(4), LEN_W'(3), '0, 1'b0);
    // The empty first segment is stepped over.
    send_beat(OP_MAP, '0, '0, INDEX_W'(0), 1'b1);
    send_beat(OP_MAP, '0, '0, INDEX_W'(4), 1'b0);
    send_beat(OP_MAP, '0, '0, INDEX_W'(5), 1'b0);
    // Largest offset inside the full-length segment.
    send_beat(OP_MAP, '0, '0, INDEX_W'(65539), 1'b0);
    send_beat(OP_MAP, '0, '0, INDEX_W'(65540), 1'b0);
    // An index that goes backwards.
    send_beat(OP_MAP, '0, '0, INDEX_W'(3), 1'b0);
    // Past the last segment; the batch stays there until the next start.
    send_beat(OP_MAP, '0, '0, INDEX_W'(65543), 1'b0);
    send_beat(OP_MAP, '0, '0, INDEX_W'(65544), 1'b0);
    send_beat(OP_MAP, '0, '0, INDEX_W'(0), 1'b0);
    send_beat(OP_MAP, '0, '0, INDEX_W'(INDEX_MAX), 1'b1);
    send_beat(OP_MAP, '0, '0, INDEX_W'(2), 1'b1);
  endtask

  // Zero segments, a count above the table depth, and the full table.
  task automatic test_count_extremes();
    int unsigned span;
    set_segment_count(COUNT_W'(0));
    send_beat(OP_MAP, '0, '0, INDEX_W'(0), 1'b1);
    send_beat(OP_MAP, '0, '0, INDEX_W'(123), 1'b0);
    set_segment_count(COUNT_W'(2047));
    span = table_span(TBL_DEPTH);
    send_beat(OP_MAP, '0, '0, INDEX_W'(INDEX_MAX), 1'b1);
    send_beat(OP_MAP, '0, '0, INDEX_W'($urandom_range(0, span - 1)), 1'b1);
    set_segment_count(COUNT_W'(TBL_DEPTH));
    send_beat(OP_MAP, '0, '0, INDEX_W'($urandom_range(0, span / 2)), 1'b1);
    // Last sample of the table lands in the final segment.
    send_beat(OP_MAP, '0, '0, INDEX_W'(span - 1), 1'b0);
  endtask

  // Phases of ascending batches with random content, mixed with noise.
  task automatic test_random_batches();
    int unsigned sent;
    int unsigned phase_items;
    int unsigned cnt;
    int unsigned lim;
    int unsigned stride;
    int unsigned cur_idx;
    int unsigned left_in_batch;
    int unsigned pick;
    int unsigned k;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0] len;
    sent = 0;
    cur_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0: cnt = 0;
        1: cnt = TBL_DEPTH;
        2: cnt = 2047;
        3: cnt = 1;
        default: cnt = $urandom_range(2, 16);
      endcase
      set_segment_count(COUNT_W'(cnt));
      lim = (cnt > TBL_DEPTH) ? TBL_DEPTH : cnt;
      phase_items = (lim > 16 || lim == 0) ? 20 : $urandom_range(60, 120);
      // Small tables get fresh lengths, mostly short, some empty, a few long.
      if (lim <= 16) begin
        for (k = 0; k < lim; k++) begin
          pick = $urandom_range(0, 9);
          len = (pick == 0) ? LEN_W'($urandom) : (pick < 3) ? '0 : LEN_W'($urandom_range(1, 24));
          send_beat(OP_WRITE, SLOT_W'(k), len, INDEX_W'($urandom), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
      stride = table_span(lim) / 6;
      if (stride == 0) stride = 1;
      left_in_batch = 0;
      for (k = 0; k < phase_items; k++) begin
        pick = $urandom_range(0, 99);
        if (left_in_batch == 0 || pick >= 96) begin
          // A new batch begins somewhere in its first stride.
          left_in_batch = $urandom_range(3, 15);
          cur_idx = $urandom_range(0, stride);
          send_beat(OP_MAP, SLOT_W'($urandom), LEN_W'($urandom), INDEX_W'(cur_idx), 1'b1);
        end else if (pick < 72) begin
          cur_idx += $urandom_range(0, stride);
          if (cur_idx > INDEX_MAX) cur_idx = INDEX_MAX;
          send_beat(OP_MAP, SLOT_W'($urandom), LEN_W'($urandom), INDEX_W'(cur_idx), 1'b0);
        end else if (pick < 80) begin
          // An index at or below the last ascending index of the batch.
          send_beat(OP_MAP, SLOT_W'($urandom), LEN_W'($urandom),
                    INDEX_W'($urandom_range(0, cur_idx)), 1'b0);
        end else if (pick < 86) begin
          send_beat(OP_MAP, SLOT_W'($urandom), LEN_W'($urandom), INDEX_W'($urandom),
                    1'($urandom_range(0, 1)));
        end else begin
          // The table changes while a batch is under way.
          slot = (lim > 0 && pick < 92) ? SLOT_W'($urandom_range(0, lim - 1)) : SLOT_W'($urandom);
          len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 24));
          send_beat(OP_WRITE, slot, len, INDEX_W'($urandom), 1'($urandom_range(0, 1)));
        end
        if (left_in_batch > 0) left_in_batch--;
        sent++;
      end
    end
  endtask

  // Result sink that switches between stall patterns.
  initial begin : result_sink
    int hold;
    sink_mode_t mode;
    out_tready = 1'b0;
    hold = 0;
    mode = SINK_OPEN;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        hold = $urandom_range(5, 80);
      end
      hold--;
      case (mode)
        SINK_OPEN:   out_tready = 1'b1;
        SINK_COIN:   out_tready = 1'($urandom_range(0, 1));
        SINK_SPARSE: out_tready = ($urandom_range(0, 7) == 0);
        default:     out_tready = (hold < 3);
      endcase
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : check_result
    seg_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: segment_number %0d, offset_in_segment %0d, status %0d",
               out_tdata[SEGNUM_W-1:0], out_tdata[SEGNUM_W+OFFSET_W-1:SEGNUM_W], out_tuser);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[SEGNUM_W-1:0] !== want.seg) begin
          $error("segment_number: expected %0d, actual %0d", want.seg, out_tdata[SEGNUM_W-1:0]);
          err_count++;
        end
        if (out_tdata[SEGNUM_W+OFFSET_W-1:SEGNUM_W] !== want.off) begin
          $error("offset_in_segment: expected %0d, actual %0d", want.off,
                 out_tdata[SEGNUM_W+OFFSET_W-1:SEGNUM_W]);
          err_count++;
        end
        if (out_tuser !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, out_tuser);
          err_count++;
        end
        case (want.st)
          ST_OK:       ok_results++;
          ST_UNSORTED: unsorted_results++;
          default:     beyond_results++;
        endcase
      end
    end
  end

  // End the run if no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("flat_index_to_segment_offset_test: done, errors");
        $finish;
      end
    end
  end

  // Reset, run every test in turn, then report.
  initial begin : run
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_WRITE;
    burst_left = 0;
    map_beats = 0;
    write_beats = 0;
    cfg_writes = 0;
    walk_seg = 0;
    walk_base = 0;
    seg_count_mirror = COUNT_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_table_fill();
    test_reset_count();
    test_directed_walk();
    test_count_extremes();
    test_random_batches();
    wait_idle();

    $display("summary: %0d map beats and %0d table writes over %0d segment count settings",
             map_beats, write_beats, cfg_writes);
    $display("summary: results in range %0d, backwards %0d, past the last segment %0d",
             ok_results, unsorted_results, beyond_results);
    if (err_count == 0) begin
      $display("flat_index_to_segment_offset_test: done, clean");
    end else begin
      $display("flat_index_to_segment_offset_test: done, errors");
    end
    $finish;
  end

endmodule
